[design/jotp_pkg.sv]
package jotp_pkg;

   // fixed formats
   localparam int IN_FRAC = 28;
   localparam int LOG_W   = 128;

   // register indexes
   localparam logic [2:0] REG_C_REAL       = 3'd0;
   localparam logic [2:0] REG_C_IMAG       = 3'd1;
   localparam logic [2:0] REG_MAX_ITER     = 3'd2;
   localparam logic [2:0] REG_BAND_STEP    = 3'd3;
   localparam logic [2:0] REG_PALETTE_BASE = 3'd4;

   // register reset values
   localparam logic [31:0] C_REAL_RST = 32'd4187593114;
   localparam logic [31:0] C_IMAG_RST = 32'd161061274;
   localparam int          MAX_ITER_RST = 256;
   localparam logic [3:0]  BAND_STEP_RST = 4'd6;
   localparam logic [7:0]  PALETTE_BASE_RST = 8'd128;

   // log2 results, Q.8
   typedef logic signed [23:0] log_type;
   localparam log_type LOG_ZERO = -24'sd1048576;
   localparam log_type CLAMP_IN = -24'sd20410;
   localparam log_type CLAMP_AX = -24'sd10205;
   localparam log_type LOG_BIAS = 24'sd2304;

   // colour constants, Q16
   localparam logic signed [47:0] K_IN    = 48'sd317983;
   localparam logic signed [47:0] K_OUT   = 48'sd590539;
   localparam logic signed [47:0] RND24   = 48'sd16777215;
   localparam logic signed [31:0] RND8    = 32'sd255;

   // multiplier operand pairs
   localparam logic [1:0] MUL_RR = 2'd0;
   localparam logic [1:0] MUL_II = 2'd1;
   localparam logic [1:0] MUL_RI = 2'd2;

   // log sources
   localparam logic [1:0] SRC_ORB  = 2'd0;
   localparam logic [1:0] SRC_NORM = 2'd1;
   localparam logic [1:0] SRC_LGA  = 2'd2;
   localparam logic [1:0] SRC_AXIS = 2'd3;

   typedef struct packed {
      logic       load;
      logic [1:0] mul_op;
      logic       mul_issue;
      logic [1:0] mul_step;
      logic       acc_clear;
      logic       acc_add;
      logic       save_sqre;
      logic       do_norm;
      logic       track;
      logic       do_update;
      logic       lg_load;
      logic [1:0] lg_src;
      logic       lg_step_en;
      logic [2:0] lg_step;
      logic       lg_save;
      logic [1:0] lg_dst;
      logic       col1;
      logic       col2;
      logic       col3;
   } cmd_type;

   typedef struct packed {
      logic cont;
      logic in_set;
      logic out_busy;
   } stat_type;

   typedef logic [255:0][7:0] frac_tab_type;

   // fractional part of log2((256+k)/256) by repeated squaring
   function automatic frac_tab_type build_frac();
      frac_tab_type t;
      logic [63:0]  m;
      logic [7:0]   fr;
      for (int k = 0; k < 256; k++) begin
         m  = 64'(256 + k) << 22;
         fr = '0;
         for (int r = 0; r < 8; r++) begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000) begin
               fr[0] = 1'b1;
               m     = m >> 1;
            end
         end
         t[k] = fr;
      end
      return t;
   endfunction

   localparam frac_tab_type FRAC_TAB = build_frac();

endpackage

[design/jotp_if.sv]
interface jotp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_real;
   logic [31:0] start_imag;
   modport source (output valid, start_real, start_imag, input ready);
   modport sink (input valid, start_real, start_imag, output ready);
endinterface

interface jotp_rsp_if #(parameter int ITER_BITS = 10);
   logic                 valid;
   logic                 ready;
   logic [7:0]           palette_index;
   logic [ITER_BITS-1:0] iteration_count;
   logic                 inside_set;
   modport source (output valid, palette_index, iteration_count, inside_set, input ready);
   modport sink (input valid, palette_index, iteration_count, inside_set, output ready);
endinterface

interface jotp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/jotp_ctrl.sv]
module jotp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  jotp_pkg::stat_type stat,
   output jotp_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SQRE  = 4'd1;
   localparam logic [3:0] S_SQIM  = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_CHECK = 4'd4;
   localparam logic [3:0] S_CROSS = 4'd5;
   localparam logic [3:0] S_UPD   = 4'd6;
   localparam logic [3:0] S_LGLD  = 4'd7;
   localparam logic [3:0] S_LGRUN = 4'd8;
   localparam logic [3:0] S_LGSAV = 4'd9;
   localparam logic [3:0] S_COL1  = 4'd10;
   localparam logic [3:0] S_COL2  = 4'd11;
   localparam logic [3:0] S_COL3  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       trk_ff, trk_in;
   logic [1:0] phase_ff, phase_in;

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         trk_ff   <= 1'b0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         trk_ff   <= trk_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      trk_in   = trk_ff;
      phase_in = phase_ff;
      cmd      = '0;
      // four partial products, then a final step that folds in the last
      cmd.mul_issue = (step_ff < 3'd4);
      cmd.mul_step  = step_ff[1:0];
      cmd.acc_add   = (step_ff != 3'd0);
      cmd.acc_clear = (step_ff == 3'd1);
      cmd.lg_step   = step_ff;
      cmd.lg_dst    = phase_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQRE;
               step_in  = '0;
               trk_in   = 1'b0;
               phase_in = '0;
            end
         end
         S_SQRE: begin
            cmd.mul_op = jotp_pkg::MUL_RR;
            step_in    = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = S_SQIM;
               step_in  = '0;
            end
         end
         S_SQIM: begin
            cmd.mul_op    = jotp_pkg::MUL_II;
            cmd.save_sqre = (step_ff == 3'd0);
            step_in       = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = S_NORM;
               step_in  = '0;
            end
         end
         S_NORM: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            cmd.do_norm   = 1'b1;
            cmd.track     = trk_ff;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            step_in       = '0;
            state_in      = stat.cont ? S_CROSS : S_LGLD;
         end
         S_CROSS: begin
            cmd.mul_op = jotp_pkg::MUL_RI;
            step_in    = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = S_UPD;
               step_in  = '0;
            end
         end
         S_UPD: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            cmd.do_update = 1'b1;
            trk_in        = 1'b1;
            state_in      = S_SQRE;
         end
         S_LGLD: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            cmd.lg_load   = 1'b1;
            if (stat.in_set) begin
               cmd.lg_src = jotp_pkg::SRC_ORB;
            end else begin
               case (phase_ff)
                  2'd0:    cmd.lg_src = jotp_pkg::SRC_NORM;
                  2'd1:    cmd.lg_src = jotp_pkg::SRC_LGA;
                  default: cmd.lg_src = jotp_pkg::SRC_AXIS;
               endcase
            end
            step_in  = '0;
            state_in = S_LGRUN;
         end
         S_LGRUN: begin
            cmd.mul_issue  = 1'b0;
            cmd.acc_add    = 1'b0;
            cmd.lg_step_en = 1'b1;
            step_in        = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               state_in = S_LGSAV;
               step_in  = '0;
            end
         end
         S_LGSAV: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            cmd.lg_save   = 1'b1;
            if (stat.in_set || phase_ff == 2'd2) begin
               state_in = S_COL1;
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = S_LGLD;
            end
         end
         S_COL1: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            cmd.col1      = 1'b1;
            state_in      = S_COL2;
         end
         S_COL2: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            cmd.col2      = 1'b1;
            state_in      = S_COL3;
         end
         S_COL3: begin
            cmd.mul_issue = 1'b0;
            cmd.acc_add   = 1'b0;
            if (!stat.out_busy) begin
               cmd.col3 = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[design/jotp_dp.sv]
module jotp_dp #(
   parameter int ITER_BITS = 10,
   parameter int FRAC_BITS = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  jotp_pkg::cmd_type     cmd,
   output jotp_pkg::stat_type    stat,
   input  logic [31:0]           start_real,
   input  logic [31:0]           start_imag,
   input  logic [31:0]           c_real,
   input  logic [31:0]           c_imag,
   input  logic [ITER_BITS-1:0]  max_iterations,
   input  logic [3:0]            band_step,
   input  logic [7:0]            palette_base,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            palette_index,
   output logic [ITER_BITS-1:0]  iteration_count,
   output logic                  inside_set
);

   localparam int M  = FRAC_BITS + 17;
   localparam int ZW = M + 1;
   localparam int HB = (M + 1) / 2;
   localparam int AW = 4 * HB;
   localparam int SW = 2 * M;
   localparam int NW = 2 * M + 1;
   localparam int UP = (FRAC_BITS >= jotp_pkg::IN_FRAC) ? FRAC_BITS - jotp_pkg::IN_FRAC : 0;
   localparam int DN = (FRAC_BITS < jotp_pkg::IN_FRAC) ? jotp_pkg::IN_FRAC - FRAC_BITS : 0;
   localparam logic [NW-1:0] BOUND = NW'(1) << (16 + 2 * FRAC_BITS);
   localparam logic [7:0] FB2 = 8'(2 * FRAC_BITS);
   localparam logic [7:0] FB1 = 8'(FRAC_BITS);

   function automatic logic signed [ZW-1:0] to_fix(input logic [31:0] v);
      logic signed [ZW-1:0] t;
      t = $signed({{(ZW-32){v[31]}}, v});
      return (t <<< UP) >>> DN;
   endfunction

   function automatic logic [M-1:0] mag(input logic signed [ZW-1:0] v);
      logic signed [ZW-1:0] n;
      n = -v;
      return v[ZW-1] ? n[M-1:0] : v[M-1:0];
   endfunction

   logic signed [ZW-1:0] re_ff, im_ff;
   logic [ITER_BITS-1:0] cnt_ff;
   logic [2*HB-1:0]      pp_ff;
   logic [1:0]           ppw_ff;
   logic [AW-1:0]        acc_ff;
   logic [SW-1:0]        sq_re_ff, sq_im_ff;
   logic [NW-1:0]        norm_ff;
   logic [jotp_pkg::LOG_W-1:0] orb_ff;
   logic [63:0]          axis_ff;
   logic [jotp_pkg::LOG_W-1:0] lg_x_ff;
   logic [6:0]           lz_ff;
   logic                 zero_ff;
   logic [7:0]           fb_ff;
   jotp_pkg::log_type    lga_ff, lgb_ff, lgc_ff;
   logic signed [23:0]   a_ff;
   logic signed [31:0]   b_ff;
   logic signed [47:0]   p_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           pal_ff;

   logic signed [ZW-1:0] cre, cim;
   logic [M-1:0]         mre, mim, opa, opb;
   logic [HB-1:0]        pa, pb;
   logic [AW-1:0]        pp_sh;
   logic [NW-1:0]        norm_in;
   logic [M-1:0]         amin;
   logic signed [AW:0]   cross_s, cross_sh;
   logic signed [SW:0]   diff, diff_sh;
   logic signed [ZW-1:0] nre, nim;
   logic [jotp_pkg::LOG_W-1:0] lg_src_v;
   logic [6:0]           lw;
   logic [6:0]           lp;
   logic signed [23:0]   pe;
   jotp_pkg::log_type    lg_res, lo_c, ax_c, hh;
   logic [31:0]          cnt_sh;
   logic signed [31:0]   nu, b_rnd;
   logic signed [47:0]   q_rnd;
   logic                 in_set;

   assign cre    = to_fix(c_real);
   assign cim    = to_fix(c_imag);
   assign mre    = mag(re_ff);
   assign mim    = mag(im_ff);
   assign in_set = (cnt_ff >= max_iterations);

   assign stat.cont     = (cnt_ff < max_iterations) && (norm_ff <= BOUND);
   assign stat.in_set   = in_set;
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   // shared multiplier, one half by half product a cycle
   always_comb begin
      case (cmd.mul_op)
         jotp_pkg::MUL_RR: begin opa = mre; opb = mre; end
         jotp_pkg::MUL_II: begin opa = mim; opb = mim; end
         default:          begin opa = mre; opb = mim; end
      endcase
      pa = cmd.mul_step[0] ? HB'(opa >> HB) : opa[HB-1:0];
      pb = cmd.mul_step[1] ? HB'(opb >> HB) : opb[HB-1:0];
      case (ppw_ff)
         2'd0:    pp_sh = AW'(pp_ff);
         2'd1:    pp_sh = AW'(pp_ff) << HB;
         default: pp_sh = AW'(pp_ff) << (2 * HB);
      endcase
   end

   // next point and traps
   always_comb begin
      norm_in  = NW'(sq_re_ff) + NW'(acc_ff[SW-1:0]);
      amin     = (mre < mim) ? mre : mim;
      cross_s  = $signed({1'b0, acc_ff});
      if (re_ff[ZW-1] ^ im_ff[ZW-1]) begin
         cross_s = -cross_s;
      end
      cross_sh = cross_s >>> (FRAC_BITS - 1);
      nim      = cross_sh[ZW-1:0] + cim;
      diff     = $signed({1'b0, sq_re_ff}) - $signed({1'b0, sq_im_ff});
      diff_sh  = diff >>> FRAC_BITS;
      nre      = diff_sh[ZW-1:0] + cre;
   end

   // log2 unit: leading one search by halving, then a table for the fraction
   always_comb begin
      case (cmd.lg_src)
         jotp_pkg::SRC_ORB:  lg_src_v = orb_ff;
         jotp_pkg::SRC_NORM: lg_src_v = jotp_pkg::LOG_W'(norm_ff);
         jotp_pkg::SRC_LGA:  lg_src_v = jotp_pkg::LOG_W'(lga_ff);
         default:            lg_src_v = jotp_pkg::LOG_W'(axis_ff);
      endcase
      lw     = 7'd64 >> cmd.lg_step;
      lp     = 7'd127 - lz_ff;
      pe     = $signed({17'b0, lp}) - $signed({16'b0, fb_ff});
      lg_res = zero_ff ? jotp_pkg::LOG_ZERO
             : (pe <<< 8) + $signed({16'b0, jotp_pkg::FRAC_TAB[lg_x_ff[126:119]]});
   end

   // colour terms
   always_comb begin
      lo_c   = (lga_ff < jotp_pkg::CLAMP_IN) ? jotp_pkg::CLAMP_IN : lga_ff;
      ax_c   = (lgc_ff < jotp_pkg::CLAMP_AX) ? jotp_pkg::CLAMP_AX : lgc_ff;
      hh     = lgb_ff - jotp_pkg::LOG_BIAS;
      cnt_sh = 32'(cnt_ff) + 32'd1;
      cnt_sh = cnt_sh << 8;
      nu     = $signed(cnt_sh) - 32'(hh);
      q_rnd  = (p_ff < 0) ? ((p_ff + jotp_pkg::RND24) >>> 24) : (p_ff >>> 24);
      b_rnd  = (b_ff < 0) ? ((b_ff + jotp_pkg::RND8) >>> 8) : (b_ff >>> 8);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         re_ff   <= to_fix(start_real);
         im_ff   <= to_fix(start_imag);
         cnt_ff  <= '0;
         orb_ff  <= '1;
         axis_ff <= '1;
      end
      if (cmd.mul_issue) begin
         pp_ff  <= pa * pb;
         ppw_ff <= 2'(cmd.mul_step[0]) + 2'(cmd.mul_step[1]);
      end
      if (cmd.acc_add) begin
         acc_ff <= (cmd.acc_clear ? '0 : acc_ff) + pp_sh;
      end
      if (cmd.save_sqre) begin
         sq_re_ff <= acc_ff[SW-1:0];
      end
      if (cmd.do_norm) begin
         sq_im_ff <= acc_ff[SW-1:0];
         norm_ff  <= norm_in;
         if (cmd.track) begin
            if (jotp_pkg::LOG_W'(norm_in) < orb_ff) begin
               orb_ff <= jotp_pkg::LOG_W'(norm_in);
            end
            if (64'(amin) < axis_ff) begin
               axis_ff <= 64'(amin);
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (cmd.do_update) begin
         re_ff <= nre;
         im_ff <= nim;
      end
      if (cmd.lg_load) begin
         lg_x_ff <= lg_src_v;
         lz_ff   <= '0;
         zero_ff <= (lg_src_v == '0);
         case (cmd.lg_src)
            jotp_pkg::SRC_LGA:  fb_ff <= 8'd0;
            jotp_pkg::SRC_AXIS: fb_ff <= FB1;
            default:            fb_ff <= FB2;
         endcase
      end
      if (cmd.lg_step_en && ((lg_x_ff >> (8'd128 - 8'(lw))) == '0)) begin
         lg_x_ff <= lg_x_ff << lw;
         lz_ff   <= lz_ff + lw;
      end
      if (cmd.lg_save) begin
         case (cmd.lg_dst)
            2'd0:    lga_ff <= lg_res;
            2'd1:    lgb_ff <= lg_res;
            default: lgc_ff <= lg_res;
         endcase
      end
      if (cmd.col1) begin
         a_ff <= in_set ? 24'(lo_c * $signed({1'b0, band_step})) : ax_c;
         b_ff <= 32'(nu * $signed({28'b0, band_step}));
      end
      if (cmd.col2) begin
         p_ff <= 48'(a_ff) * (in_set ? jotp_pkg::K_IN : jotp_pkg::K_OUT);
      end
      if (cmd.col3) begin
         pal_ff          <= palette_base + (in_set ? 8'd128 : b_rnd[7:0]) - q_rnd[7:0];
         iteration_count <= cnt_ff;
         inside_set      <= in_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.col3) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign palette_index = pal_ff;

endmodule

[design/julia_orbit_trap_pixel.sv]
// sequence: setup, then the orbit steps, then the log2 passes (one for inside points,
// three for escaped points) and the colour arithmetic
// throughput: one item at a time; each orbit step runs on the shared half-width multiplier
// (4 passes per product, 3 products per step)
// reset: synchronous, active high; configuration registers return to their reset values, no item in flight
module julia_orbit_trap_pixel #(
   parameter int ITER_BITS = 10,
   parameter int FRAC_BITS = 28
) (
   input logic          clock,
   input logic          reset,
   jotp_req_if.sink     req_ch,
   jotp_rsp_if.source   rsp_ch,
   jotp_csr_if.sink     csr_ch
);

   // configuration registers
   logic [31:0]          c_real_ff;
   logic [31:0]          c_imag_ff;
   logic [ITER_BITS-1:0] max_iter_ff;
   logic [3:0]           band_step_ff;
   logic [7:0]           palette_base_ff;

   jotp_pkg::cmd_type  cmd;
   jotp_pkg::stat_type stat;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff       <= jotp_pkg::C_REAL_RST;
         c_imag_ff       <= jotp_pkg::C_IMAG_RST;
         max_iter_ff     <= ITER_BITS'(jotp_pkg::MAX_ITER_RST);
         band_step_ff    <= jotp_pkg::BAND_STEP_RST;
         palette_base_ff <= jotp_pkg::PALETTE_BASE_RST;
      end else if (csr_ch.valid) begin
         // unknown indexes are dropped
         case (csr_ch.index)
            jotp_pkg::REG_C_REAL:       c_real_ff       <= csr_ch.data;
            jotp_pkg::REG_C_IMAG:       c_imag_ff       <= csr_ch.data;
            jotp_pkg::REG_MAX_ITER:     max_iter_ff     <= csr_ch.data[ITER_BITS-1:0];
            jotp_pkg::REG_BAND_STEP:    band_step_ff    <= csr_ch.data[3:0];
            jotp_pkg::REG_PALETTE_BASE: palette_base_ff <= csr_ch.data[7:0];
            default: ;
         endcase
      end
   end

   // sequencer: squares, escape test, cross product, update, then logs and colour
   jotp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // orbit arithmetic, trap tracking, log2 unit and result register
   jotp_dp #(
      .ITER_BITS (ITER_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .start_real      (req_ch.start_real),
      .start_imag      (req_ch.start_imag),
      .c_real          (c_real_ff),
      .c_imag          (c_imag_ff),
      .max_iterations  (max_iter_ff),
      .band_step       (band_step_ff),
      .palette_base    (palette_base_ff),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .palette_index   (rsp_ch.palette_index),
      .iteration_count (rsp_ch.iteration_count),
      .inside_set      (rsp_ch.inside_set)
   );

endmodule

[sim/julia_orbit_trap_pixel_check.sv]
module julia_orbit_trap_pixel_check (
   input  logic clock,
   input  logic reset,
   jotp_req_if  req,
   jotp_rsp_if  rsp,
   jotp_csr_if  csr,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] palette;
      logic [9:0] count;
      logic       in_set;
   } pixel_type;

   pixel_type   pixel_q[$];
   logic [31:0] cr, ci;
   logic [9:0]  iter_lim;
   logic [3:0]  band;
   logic [7:0]  base;

   localparam logic [127:0] ESCAPE_BOUND = 128'd1 << 72;

   // fraction bits of log2((256+k)/256) by repeated squaring
   function automatic int frac_of(logic [7:0] k);
      longint unsigned m;
      int fr;
      m  = longint'(256 + k) << 22;
      fr = 0;
      for (int r = 0; r < 8; r++) begin
         m  = (m * m) >> 30;
         fr = fr << 1;
         if (m >= 64'h8000_0000) begin
            fr = fr | 1;
            m  = m >> 1;
         end
      end
      return fr;
   endfunction

   // log2 in q.8 of an unsigned value with fb fraction bits
   function automatic int log2_q8(logic [127:0] x, int fb);
      int p;
      logic [7:0] k;
      if (x == 0) return int'(jotp_pkg::LOG_ZERO);
      p = 127;
      while (!x[p]) p--;
      if (p >= 8) k = 8'(x >> (p - 8));
      else k = 8'(x << (8 - p));
      return (p - fb) * 256 + frac_of(k);
   endfunction

   function automatic pixel_type colour_pixel(logic [31:0] s_re, logic [31:0] s_im);
      pixel_type res;
      longint re, im, cre, cim, nre, nim, lg, hh, nu, ax, colour;
      longint unsigned ar, ai, am, axis_min;
      logic signed [127:0] w_re, w_im, sqr, sqi, prod, diff;
      logic [127:0] nrm, orb;
      int cnt;
      re  = $signed(s_re);
      im  = $signed(s_im);
      cre = $signed(cr);
      cim = $signed(ci);
      w_re = re;
      w_im = im;
      sqr  = w_re * w_re;
      sqi  = w_im * w_im;
      nrm  = sqr + sqi;
      orb  = '1;
      axis_min = '1;
      cnt  = 0;
      while (cnt < iter_lim && nrm <= ESCAPE_BOUND) begin
         prod = w_re * w_im;
         diff = sqr - sqi;
         nim  = longint'(prod >>> 27) + cim;
         nre  = longint'(diff >>> 28) + cre;
         re   = nre;
         im   = nim;
         w_re = re;
         w_im = im;
         sqr  = w_re * w_re;
         sqi  = w_im * w_im;
         nrm  = sqr + sqi;
         if (nrm < orb) orb = nrm;
         ar = re < 0 ? -re : re;
         ai = im < 0 ? -im : im;
         am = ar < ai ? ar : ai;
         if (am < axis_min) axis_min = am;
         cnt++;
      end
      res.in_set = cnt >= iter_lim;
      if (res.in_set) begin
         lg = log2_q8(orb, 56);
         if (lg < jotp_pkg::CLAMP_IN) lg = jotp_pkg::CLAMP_IN;
         colour = longint'(base) + 128 - ((lg * longint'(band) * 317983) / 16777216);
      end else begin
         lg = log2_q8(nrm, 56);
         hh = log2_q8(128'(lg), 0) - 2304;
         nu = (longint'(cnt) + 1) * 256 - hh;
         ax = log2_q8(128'(axis_min), 28);
         if (ax < jotp_pkg::CLAMP_AX) ax = jotp_pkg::CLAMP_AX;
         colour = longint'(base) + (nu * longint'(band)) / 256
                  - ((ax * 590539) / 16777216);
      end
      res.palette = colour[7:0];
      res.count   = cnt[9:0];
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         cr       <= jotp_pkg::C_REAL_RST;
         ci       <= jotp_pkg::C_IMAG_RST;
         iter_lim <= 10'(jotp_pkg::MAX_ITER_RST);
         band     <= jotp_pkg::BAND_STEP_RST;
         base     <= jotp_pkg::PALETTE_BASE_RST;
         pixel_q.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               jotp_pkg::REG_C_REAL:       cr       <= csr.data;
               jotp_pkg::REG_C_IMAG:       ci       <= csr.data;
               jotp_pkg::REG_MAX_ITER:     iter_lim <= csr.data[9:0];
               jotp_pkg::REG_BAND_STEP:    band     <= csr.data[3:0];
               jotp_pkg::REG_PALETTE_BASE: base     <= csr.data[7:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            pixel_q.push_back(colour_pixel(req.start_real, req.start_imag));
         if (rsp.valid && rsp.ready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected item pal=%0d cnt=%0d in=%0d", $time,
                  rsp.palette_index, rsp.iteration_count, rsp.inside_set);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               if (rsp.palette_index !== want.palette || rsp.iteration_count !== want.count
                   || rsp.inside_set !== want.in_set) begin
                  $display("%0t: mismatch expected pal=%0d cnt=%0d in=%0d got pal=%0d cnt=%0d in=%0d",
                     $time, want.palette, want.count, want.in_set, rsp.palette_index,
                     rsp.iteration_count, rsp.inside_set);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= pixel_q.size();
      end
   end
endmodule

[sim/julia_orbit_trap_pixel_test.sv]
module julia_orbit_trap_pixel_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending;
   int   send_idle, recv_stall;   // idle percentages of the current phase
   int   hold_cycles = 0;         // long receiver hold-off request
   int   quiet = 0;               // cycles with nothing accepted

   jotp_req_if req();
   jotp_rsp_if #(.ITER_BITS(10)) rsp();
   jotp_csr_if csr();

   julia_orbit_trap_pixel #(.ITER_BITS(10), .FRAC_BITS(28)) uut (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp), .csr_ch(csr)
   );

   julia_orbit_trap_pixel_check check (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   // known values on every input from time zero
   initial begin
      req.valid = 1'b0;
      req.start_real = '0;
      req.start_imag = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      rsp.ready = 1'b0;
   end

   // result side: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp.ready <= ($urandom % 100) >= recv_stall;
   end

   // watchdog on accepted traffic; the worst item is up to 1023 orbit steps plus the hold-off
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready))
         quiet <= 0;
      else if (quiet >= 80000) begin
         $display("julia_orbit_trap_pixel test failed");
         $finish;
      end else
         quiet <= quiet + 1;
   end

   // register write; the block is idle whenever this is called
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // offer one start point, valid stays high into the next item unless an idle gap falls
   task automatic send_point(logic [31:0] s_re, logic [31:0] s_im);
      @(negedge clock);
      while (($urandom % 100) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.start_real <= s_re;
      req.start_imag <= s_im;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_all(logic [31:0] c_re, logic [31:0] c_im, logic [9:0] lim,
                          logic [3:0] bnd, logic [7:0] bse);
      write_reg(jotp_pkg::REG_C_REAL, c_re);
      write_reg(jotp_pkg::REG_C_IMAG, c_im);
      write_reg(jotp_pkg::REG_MAX_ITER, 32'(lim));
      write_reg(jotp_pkg::REG_BAND_STEP, 32'(bnd));
      write_reg(jotp_pkg::REG_PALETTE_BASE, 32'(bse));
   endtask

   // mostly points near the set, some anywhere in the 32-bit range
   function automatic logic [31:0] rand_coord();
      case ($urandom % 8)
         0, 1:    return $urandom;
         2:       return 32'($urandom_range(0, 1073741824)) - 32'd536870912;
         default: return 32'($urandom_range(0, 940000000)) - 32'd470000000;
      endcase
   endfunction

   function automatic logic [31:0] rand_c();
      return 32'($urandom_range(0, 500000000)) - 32'd250000000;
   endfunction

   logic [9:0] lim_list  [8] = '{10'd16, 10'd40, 10'd24, 10'd1023, 10'd64, 10'd32, 10'd1, 10'd48};
   logic [3:0] band_list [8] = '{4'd3, 4'd11, 4'd0, 4'd15, 4'd6, 4'd7, 4'd4, 4'd9};
   logic [7:0] base_list [8] = '{8'd8, 8'd228, 8'd0, 8'd255, 8'd128, 8'd77, 8'd170, 8'd31};

   initial begin
      int n_items;
      send_idle = 0;
      recv_stall = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, start points at the field extremes
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7fff_ffff);
      send_point(32'h7fff_ffff, 32'h8000_0000);
      send_point(32'h1000_0000, 32'hf000_0000);
      drain();
      // zero c: origin stays put (zero traps), unit point stays on the circle
      set_all(32'h0, 32'h0, 10'd20, 4'd15, 8'd255);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h1000_0000, 32'h0000_0000);
      send_point(32'h0000_0000, 32'h1000_0000);
      send_point(32'h2000_0000, 32'h0000_0000);
      drain();
      // zero iteration limit, then a single step
      write_reg(jotp_pkg::REG_MAX_ITER, 32'd0);
      send_point(32'h0400_0000, 32'hfc00_0000);
      send_point(32'h7fff_ffff, 32'h8000_0000);
      drain();
      write_reg(jotp_pkg::REG_MAX_ITER, 32'hffff_fc01);
      send_point(32'h0400_0000, 32'h0400_0000);
      send_point(32'h3000_0000, 32'h3000_0000);
      drain();
      // writes to unused indexes must change nothing
      write_reg(3'd5, $urandom);
      write_reg(3'd6, $urandom);
      write_reg(3'd7, 32'hffff_ffff);
      set_all(32'h8000_0000, 32'h7fff_ffff, 10'd8, 4'd0, 8'd0);
      send_point(32'h0100_0000, 32'h0000_0000);
      send_point(32'hfff0_0000, 32'h0010_0000);
      drain();
      set_all(32'h7fff_ffff, 32'h8000_0000, 10'd8, 4'd3, 8'd8);
      send_point(32'h0000_0000, 32'h0000_0000);
      drain();

      // random phases, each with its own settings and idle pattern
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 84; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 84; end
            default: begin send_idle = 33; recv_stall = 33; end
         endcase
         if (ph == 7) set_all($urandom, $urandom, lim_list[ph], band_list[ph], base_list[ph]);
         else set_all(rand_c(), rand_c(), lim_list[ph], band_list[ph], base_list[ph]);
         n_items = (lim_list[ph] == 10'd1023) ? 12 : 250;
         for (int i = 0; i < n_items; i++) begin
            // long receiver hold-off while points keep coming
            if (ph == 2 && i == 60) hold_cycles = 3000;
            // sender waits out every result in flight
            if (ph == 1 && i == 100) begin
               @(negedge clock);
               req.valid <= 1'b0;
               while (pending != 0) @(posedge clock);
            end
            send_point(rand_coord(), rand_coord());
         end
         drain();
      end

      if (fail_count == 0)
         $display("julia_orbit_trap_pixel test passed");
      else
         $display("julia_orbit_trap_pixel test failed");
      $finish;
   end
endmodule
